>>> design/jpeg_segment_extractor_defines.svh
// Assertion helpers shared by the design files
`ifndef JPEG_SEGMENT_EXTRACTOR_DEFINES_SVH
`define JPEG_SEGMENT_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define JSE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jse assertion failed");

// next-cycle implication, disabled while reset is high
`define JSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jse assertion failed");

`endif

>>> design/jse_pkg.sv
package jse_pkg;

   localparam int FILL_LIMIT = 16;
   localparam int RQ_DEPTH   = 4;
   localparam int RQ_PTR_W   = 2;
   localparam int RQ_CNT_W   = 3;

   localparam logic [7:0]  MK_FILL      = 8'hFF;
   localparam logic [7:0]  MK_SOI       = 8'hD8;
   localparam logic [7:0]  MK_EOI       = 8'hD9;
   localparam logic [7:0]  MK_SOS       = 8'hDA;
   localparam logic [7:0]  TARGET_RESET = 8'hE2;
   localparam logic [23:0] TOTAL_MAX    = 24'hFFFFFF;
   localparam logic [2:0]  SHORT_FRAME  = 3'd4;

   typedef enum logic [2:0] {
      PH_SOI_FIRST,
      PH_SOI_SECOND,
      PH_MARKER,
      PH_LEN_HIGH,
      PH_LEN_LOW,
      PH_PAYLOAD,
      PH_DONE,
      PH_ERROR
   } jse_phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_NOT_JPEG,
      ST_FILL,
      ST_LENGTH,
      ST_PREMATURE,
      ST_NONE
   } jse_status_type;

   typedef enum logic {
      KIND_PAYLOAD,
      KIND_STATUS
   } jse_kind_type;

   typedef struct packed {
      jse_kind_type   kind;
      logic [7:0]     payload_byte;
      jse_status_type status;
      logic [23:0]    extracted_bytes;
      logic           last;
   } jse_result_type;

   typedef struct packed {
      logic [1:0]     count;
      jse_result_type first;
      jse_result_type second;
   } jse_push_type;

endpackage

>>> design/jse_fifo.sv
`include "jpeg_segment_extractor_defines.svh"

module jse_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  jse_pkg::jse_push_type   push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output jse_pkg::jse_result_type out_result
);
   import jse_pkg::*;

   jse_result_type        mem [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   count_ff, count_in;
   logic                  pop;

   assign out_valid  = (count_ff != '0);
   assign pop        = out_valid && out_ready;
   assign room       = (count_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign out_result = mem[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RQ_PTR_W'(pop);
   assign count_in  = count_ff + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + RQ_PTR_W'(1)] <= push.second;
      end
   end

   `JSE_ASSERT_IMPL(a_no_overflow, push.count != 2'd0,
      (4'(count_ff) + 4'(push.count)) <= 4'(RQ_DEPTH))
   `JSE_ASSERT_IMPL(a_ptr_match, 1'b1, (wr_ptr_ff - rd_ptr_ff) == count_ff[RQ_PTR_W-1:0])
   `JSE_ASSERT_NEXT(a_pop_drains, pop && push.count == 2'd0,
      count_ff == $past(count_ff) - RQ_CNT_W'(1))

endmodule

>>> design/jpeg_segment_extractor.sv
// A result is taken at rsp from the head of the result queue.
// Throughput: one byte per cycle while req_tready is high; a final byte that is
// also a payload byte yields two results, drained one per cycle through a
// 4-entry result queue while rsp_tready is high. req_tready drops while the
// queue holds more than two results. Reset (synchronous, active high) clears
// frame state and the queue and loads target_marker with 0xE2.
`include "jpeg_segment_extractor_defines.svh"

module jpeg_segment_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // payload_byte[7:0], status[10:8], extracted_bytes[34:11]
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata    // target_marker
);
   import jse_pkg::*;

   jse_phase_type  phase_ff, phase_in;
   logic [4:0]     fill_ff, fill_in;
   logic [7:0]     len_high_ff, len_high_in;
   logic [15:0]    remain_ff, remain_in;
   logic           sel_ff, sel_in;
   logic [2:0]     fbc_ff, fbc_in;
   logic [23:0]    total_ff, total_in;
   jse_status_type err_ff, err_in;
   logic [7:0]     target_ff;

   logic [2:0]     fbc_upd;
   logic [23:0]    total_upd;
   jse_status_type err_upd;
   logic [15:0]    len_word;
   logic [15:0]    remain_dec;
   logic           fire;
   logic           emit_payload;
   logic           room;
   jse_push_type   push;
   jse_result_type head;
   jse_status_type frame_status;

   assign req_tready   = room;
   assign fire         = req_tvalid && req_tready;
   assign emit_payload = fire && (phase_ff == PH_PAYLOAD) && sel_ff;
   assign len_word     = {len_high_ff, req_tdata};
   assign remain_dec   = (remain_ff != '0) ? remain_ff - 16'd1 : remain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SOI_FIRST;
         fill_ff     <= '0;
         len_high_ff <= '0;
         remain_ff   <= '0;
         sel_ff      <= 1'b0;
         fbc_ff      <= '0;
         total_ff    <= '0;
         err_ff      <= ST_OK;
      end else begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         len_high_ff <= len_high_in;
         remain_ff   <= remain_in;
         sel_ff      <= sel_in;
         fbc_ff      <= fbc_in;
         total_ff    <= total_in;
         err_ff      <= err_in;
      end
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      len_high_in = len_high_ff;
      remain_in   = remain_ff;
      sel_in      = sel_ff;
      err_upd     = err_ff;
      total_upd   = total_ff;
      fbc_upd     = (fbc_ff < SHORT_FRAME) ? fbc_ff + 3'd1 : fbc_ff;

      unique case (phase_ff)
         PH_SOI_FIRST: begin
            if (req_tdata != MK_FILL) begin
               err_upd  = ST_NOT_JPEG;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_SOI_SECOND;
            end
         end
         PH_SOI_SECOND: begin
            if (req_tdata != MK_SOI) begin
               err_upd  = ST_NOT_JPEG;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_MARKER;
            end
         end
         PH_MARKER: begin
            if (!req_tlast) begin
               if (req_tdata == MK_FILL) begin
                  if (fill_ff >= 5'(FILL_LIMIT)) begin
                     err_upd  = ST_FILL;
                     phase_in = PH_ERROR;
                  end else begin
                     fill_in = fill_ff + 5'd1;
                  end
               end else if (req_tdata == MK_EOI || req_tdata == MK_SOS) begin
                  phase_in = PH_DONE;
               end else begin
                  sel_in   = (req_tdata == target_ff);
                  fill_in  = '0;
                  phase_in = PH_LEN_HIGH;
               end
            end
         end
         PH_LEN_HIGH: begin
            if (!req_tlast) begin
               len_high_in = req_tdata;
               phase_in    = PH_LEN_LOW;
            end
         end
         PH_LEN_LOW: begin
            if (len_word < 16'd2) begin
               err_upd  = ST_LENGTH;
               phase_in = PH_ERROR;
            end else if (len_word == 16'd2) begin
               phase_in = PH_MARKER;
            end else begin
               remain_in = len_word - 16'd2;
               if (req_tlast) begin
                  err_upd  = ST_PREMATURE;
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (sel_ff && total_ff != TOTAL_MAX) begin
               total_upd = total_ff + 24'd1;
            end
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_MARKER;
            end else if (req_tlast) begin
               err_upd  = ST_PREMATURE;
               phase_in = PH_ERROR;
            end
         end
         PH_DONE: begin
         end
         PH_ERROR: begin
         end
      endcase

      fbc_in   = fbc_upd;
      total_in = total_upd;
      err_in   = err_upd;

      if (!fire) begin
         phase_in    = phase_ff;
         fill_in     = fill_ff;
         len_high_in = len_high_ff;
         remain_in   = remain_ff;
         sel_in      = sel_ff;
         fbc_in      = fbc_ff;
         total_in    = total_ff;
         err_in      = err_ff;
      end else if (req_tlast) begin
         phase_in    = PH_SOI_FIRST;
         fill_in     = '0;
         len_high_in = '0;
         remain_in   = '0;
         sel_in      = 1'b0;
         fbc_in      = '0;
         total_in    = '0;
         err_in      = ST_OK;
      end
   end

   // outputs
   always_comb begin
      jse_result_type pay_res;
      jse_result_type st_res;

      if (fbc_upd < SHORT_FRAME) begin
         frame_status = ST_SHORT;
      end else if (err_upd != ST_OK) begin
         frame_status = err_upd;
      end else if (total_upd == '0) begin
         frame_status = ST_NONE;
      end else begin
         frame_status = ST_OK;
      end

      pay_res.kind            = KIND_PAYLOAD;
      pay_res.payload_byte    = req_tdata;
      pay_res.status          = ST_OK;
      pay_res.extracted_bytes = '0;
      pay_res.last            = 1'b0;

      st_res.kind             = KIND_STATUS;
      st_res.payload_byte     = '0;
      st_res.status           = frame_status;
      st_res.extracted_bytes  = total_upd;
      st_res.last             = 1'b1;

      push.first  = emit_payload ? pay_res : st_res;
      push.second = st_res;
      push.count  = 2'(emit_payload) + 2'(fire && req_tlast);
   end

   jse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (head)
   );

   assign rsp_tdata = {5'b0, head.extracted_bytes, head.status, head.payload_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   `JSE_ASSERT_NEXT(a_frame_clears, fire && req_tlast,
      phase_ff == PH_SOI_FIRST && total_ff == '0 && err_ff == ST_OK)
   `JSE_ASSERT_IMPL(a_error_quiet, fire && phase_ff == PH_ERROR,
      push.count == (req_tlast ? 2'd1 : 2'd0))
   `JSE_ASSERT_IMPL(a_error_phase, err_ff != ST_OK, phase_ff == PH_ERROR)

endmodule
